FILE: design/ckbs_pkg.sv
// Shared types and constants of the circular keyframe blend selector.
package ckbs_pkg;

    // Day fraction: a time is TIME_W bits, one whole day is DAY_UNITS
    localparam int TIME_W = 16;
    localparam int SPAN_W = TIME_W + 1;
    localparam logic [SPAN_W-1:0] DAY_UNITS = {1'b1, {TIME_W{1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTH_MODE = 1'b0,
        REG_KNOT_COUNT  = 1'b1
    } t_cfg_reg;

    // Operation codes of an input item
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LAST,
        ST_CHECK,
        ST_SCAN,
        ST_EQ_TOP,
        ST_SPAN,
        ST_MIRROR,
        ST_SELECT,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } t_state;

    // Table read address source
    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_SCAN
    } t_addr_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;
        logic      query;
        logic      cap_t0;
        logic      check;
        logic      scan;
        logic      eq_top;
        logic      span;
        logic      mirror;
        logic      select;
        logic      prep;
        logic      div;
        logic      fin;
        t_addr_sel addr_sel;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic wrap_hit;
        logic scan_more;
        logic scan_eq;
        logic div_done;
    } t_status;

endpackage

FILE: design/ckbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ckbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ckbs_ctrl.sv
// Controller state machine: sequences table scan, blend math and divide.
module ckbs_ctrl
    import ckbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_operation,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && (t_op'(i_operation) == OP_QUERY)) begin
                    n_state = ST_RD_LAST;
                end
            end
            ST_RD_LAST: n_state = ST_CHECK;
            ST_CHECK: begin
                n_state = i_status.wrap_hit ? ST_SPAN : ST_SCAN;
            end
            ST_SCAN: begin
                priority if (i_status.scan_more) begin
                    n_state = ST_SCAN;
                end else if (i_status.scan_eq) begin
                    n_state = ST_EQ_TOP;
                end else begin
                    n_state = ST_SPAN;
                end
            end
            ST_EQ_TOP: n_state = ST_SPAN;
            ST_SPAN:   n_state = ST_MIRROR;
            ST_MIRROR: n_state = ST_SELECT;
            ST_SELECT: n_state = ST_PREP;
            ST_PREP:   n_state = ST_DIV;
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_ZERO;
        o_busy         = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.load  = i_start && (t_op'(i_operation) == OP_LOAD);
                o_cmd.query = i_start && (t_op'(i_operation) == OP_QUERY);
            end
            ST_RD_LAST: begin
                o_cmd.cap_t0   = 1'b1;
                o_cmd.addr_sel = ADDR_LAST;
            end
            ST_CHECK:  o_cmd.check = 1'b1;
            ST_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.addr_sel = ADDR_SCAN;
            end
            ST_EQ_TOP: o_cmd.eq_top = 1'b1;
            ST_SPAN:   o_cmd.span   = 1'b1;
            ST_MIRROR: o_cmd.mirror = 1'b1;
            ST_SELECT: o_cmd.select = 1'b1;
            ST_PREP:   o_cmd.prep   = 1'b1;
            ST_DIV:    o_cmd.div    = 1'b1;
            ST_FIN:    o_cmd.fin    = 1'b1;
            default:   o_busy       = 1'b1;
        endcase
    end

endmodule

FILE: design/ckbs_datapath.sv
// Datapath: knot table, config registers, span math and bit-serial divider.
module ckbs_datapath
    import ckbs_pkg::*;
#(
    parameter int MAX_KNOTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cmd                               i_cmd,
    output t_status                            o_status,
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [$clog2(MAX_KNOTS+1)-1:0]     i_cfg_data,
    input  logic [$clog2(MAX_KNOTS)-1:0]       i_knot_index,
    input  logic [TIME_W-1:0]                  i_knot_time,
    input  logic [TIME_W-1:0]                  i_query_time,
    output logic                               o_valid,
    output logic [$clog2(MAX_KNOTS)-1:0]       o_bottom_index,
    output logic [$clog2(MAX_KNOTS)-1:0]       o_top_index,
    output logic [FRAC_BITS:0]                 o_blend
);

    localparam int IDX_W   = $clog2(MAX_KNOTS);
    localparam int CNT_W   = $clog2(MAX_KNOTS + 1);
    localparam int DCNT_W  = $clog2(FRAC_BITS);
    localparam int BLEND_W = FRAC_BITS + 1;
    localparam logic [BLEND_W-1:0] BLEND_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        BK_DIVIDE,
        BK_ZERO,
        BK_ONE
    } t_blend_kind;

    // Forward distance from a to b around the day
    function automatic logic [SPAN_W-1:0] circ_span(
        input logic [SPAN_W-1:0] a,
        input logic [SPAN_W-1:0] b
    );
        logic [SPAN_W-1:0] d;
        if (b < a) begin
            d = (DAY_UNITS - a) + b;
        end else begin
            d = b - a;
        end
        return d;
    endfunction

    // Configuration registers
    logic             r_smooth;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 1'b1;
            r_count  <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SMOOTH_MODE: r_smooth <= i_cfg_data[0];
                REG_KNOT_COUNT:  r_count  <= i_cfg_data;
                default:         r_smooth <= r_smooth;
            endcase
        end
    end

    // Index of the last knot in use, count clamped to 1..MAX_KNOTS
    logic [IDX_W-1:0] w_last;
    always_comb begin
        priority if (r_count == '0) begin
            w_last = '0;
        end else if (r_count > CNT_W'(MAX_KNOTS)) begin
            w_last = IDX_W'(MAX_KNOTS - 1);
        end else begin
            w_last = IDX_W'(r_count - CNT_W'(1));
        end
    end

    // Knot table
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  w_raddr;
    logic [TIME_W-1:0] w_rdata;
    logic              w_we;

    assign w_we = i_cmd.load && ({1'b0, i_knot_index} < (IDX_W + 1)'(MAX_KNOTS));

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_ZERO: w_raddr = '0;
            ADDR_LAST: w_raddr = w_last;
            ADDR_SCAN: w_raddr = (r_idx < w_last) ? r_idx + IDX_W'(1) : r_idx;
            default:   w_raddr = '0;
        endcase
    end

    ckbs_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAX_KNOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_knot_index),
        .i_wdata (i_knot_time),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Search state
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_t0;
    logic [TIME_W-1:0] r_prev;
    logic [IDX_W-1:0]  r_bot_idx;
    logic [IDX_W-1:0]  r_top_idx;
    logic [TIME_W-1:0] r_tbot;
    logic [TIME_W-1:0] r_ttop;

    assign o_status.wrap_hit  = (r_now < r_t0) || (w_rdata <= r_now);
    assign o_status.scan_more = (r_idx < w_last) && (w_rdata < r_now);
    assign o_status.scan_eq   = (w_rdata == r_now);

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_now <= i_query_time;
        end
        if (i_cmd.cap_t0) begin
            r_t0 <= w_rdata;
        end
        // Before the first or at/after the last knot: last to first
        if (i_cmd.check) begin
            r_idx     <= '0;
            r_bot_idx <= w_last;
            r_top_idx <= '0;
            r_tbot    <= w_rdata;
            r_ttop    <= r_t0;
        end
        // One knot per cycle; the read of the following slot is already out
        if (i_cmd.scan) begin
            if (o_status.scan_more) begin
                r_idx  <= r_idx + IDX_W'(1);
                r_prev <= w_rdata;
            end else if (o_status.scan_eq) begin
                r_bot_idx <= r_idx;
                r_tbot    <= w_rdata;
                r_top_idx <= (r_idx < w_last) ? r_idx + IDX_W'(1) : r_idx;
            end else begin
                r_bot_idx <= (r_idx != '0) ? r_idx - IDX_W'(1) : '0;
                r_tbot    <= (r_idx != '0) ? r_prev : w_rdata;
                r_top_idx <= r_idx;
                r_ttop    <= w_rdata;
            end
        end
        // Exact hit: top time arrives in the cycle after the scan ends
        if (i_cmd.eq_top) begin
            r_ttop <= w_rdata;
        end
    end

    // Blend arithmetic, one step per cycle
    logic [SPAN_W-1:0] w_from;
    logic [SPAN_W-1:0] w_to;
    logic [SPAN_W-1:0] w_now;
    logic [SPAN_W-1:0] r_rf;
    logic [SPAN_W-1:0] r_rt;
    logic [SPAN_W-1:0] r_dur;
    logic [SPAN_W-1:0] r_el;
    logic              r_opposite;
    logic              r_c_from;
    logic              r_c_to;
    logic [SPAN_W-1:0] r_th_from;
    logic [SPAN_W-1:0] r_th_to;
    logic [SPAN_W-1:0] r_num;
    logic [SPAN_W-1:0] r_den;
    t_blend_kind       r_kind;

    assign w_from = {1'b0, r_tbot};
    assign w_to   = {1'b0, r_ttop};
    assign w_now  = {1'b0, r_now};

    always_ff @(posedge i_clk) begin
        // Spans and mirror points
        if (i_cmd.span) begin
            r_rf       <= DAY_UNITS - w_from;
            r_rt       <= DAY_UNITS - w_to;
            r_dur      <= circ_span(w_from, w_to);
            r_el       <= circ_span(w_from, w_now);
            r_opposite <= ((DAY_UNITS - w_from) < w_from) != ((DAY_UNITS - w_to) < w_to);
        end
        // Thresholds at the mirrored points
        if (i_cmd.mirror) begin
            r_c_from  <= r_rf < w_to;
            r_c_to    <= w_from < r_rt;
            r_th_from <= circ_span(w_from, r_rf);
            r_th_to   <= circ_span(w_from, r_rt);
        end
        // Choose hold, saturate or divide operands
        if (i_cmd.select) begin
            priority if (r_opposite && r_c_from) begin
                r_kind <= ((r_el < r_th_from) || (r_dur <= r_th_from)) ? BK_ZERO : BK_DIVIDE;
                r_num  <= r_el - r_th_from;
                r_den  <= r_dur - r_th_from;
            end else if (r_opposite && r_c_to) begin
                r_kind <= (r_th_to < r_el) ? BK_ONE : BK_DIVIDE;
                r_num  <= r_el;
                r_den  <= r_th_to;
            end else begin
                r_kind <= BK_DIVIDE;
                r_num  <= r_el;
                r_den  <= r_dur;
            end
        end
        // Zero span gives 0, a ratio of one or more saturates
        if (i_cmd.prep && (r_kind == BK_DIVIDE)) begin
            if (r_den == '0) begin
                r_kind <= BK_ZERO;
            end else if (r_num >= r_den) begin
                r_kind <= BK_ONE;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle
    logic [SPAN_W-1:0]    r_rem;
    logic [FRAC_BITS-1:0] r_q;
    logic [DCNT_W-1:0]    r_dcnt;
    logic [SPAN_W:0]      w_shift;
    logic                 w_fit;

    assign w_shift = {r_rem, 1'b0};
    assign w_fit   = w_shift >= {1'b0, r_den};
    assign o_status.div_done = (r_kind != BK_DIVIDE) || (r_dcnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rem  <= r_num;
            r_q    <= '0;
            r_dcnt <= DCNT_W'(FRAC_BITS - 1);
        end
        if (i_cmd.div) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
            r_q    <= {r_q[FRAC_BITS-2:0], w_fit};
            r_rem  <= w_fit ? SPAN_W'(w_shift - {1'b0, r_den}) : SPAN_W'(w_shift);
        end
    end

    // Result registers
    logic               r_valid;
    logic [IDX_W-1:0]   r_out_bot;
    logic [IDX_W-1:0]   r_out_top;
    logic [BLEND_W-1:0] r_out_blend;
    logic [BLEND_W-1:0] w_blend;

    always_comb begin
        unique case (r_kind)
            BK_ZERO:   w_blend = '0;
            BK_ONE:    w_blend = BLEND_ONE;
            BK_DIVIDE: begin
                if (r_smooth) begin
                    w_blend = {1'b0, r_q};
                end else begin
                    w_blend = r_q[FRAC_BITS-1] ? BLEND_ONE : '0;
                end
            end
            default:   w_blend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_bot   <= r_bot_idx;
            r_out_top   <= r_top_idx;
            r_out_blend <= w_blend;
        end
    end

    assign o_valid        = r_valid;
    assign o_bottom_index = r_out_bot;
    assign o_top_index    = r_out_top;
    assign o_blend        = r_out_blend;

endmodule

FILE: design/circular_keyframe_blend_selector.sv
// Top level of the circular keyframe blend selector.
//
// Command channel: an item transfers on a rising edge with start high and
// busy low. i_operation selects a knot load (slot i_knot_index gets
// i_knot_time) or a query at i_query_time. A load finishes at its transfer
// and busy stays low. Loads go in ascending time order; the user must keep
// to this, as the block does not enforce it. A query raises busy. The knot
// scan reads one table entry per cycle, then the span math (span, mirror,
// select and prep steps) and a bit-serial divider for FRAC_BITS quotient
// bits follow. The result (bottom, top, blend) is shown for one cycle with
// o_valid high, which is also the first cycle busy is low again. When the
// result comes depends on the scan length and on whether the divider runs.
// The receiver cannot stall the result.
// Configuration writes via i_cfg_we/i_cfg_index/i_cfg_data take effect at
// once; the user must make them while the block is idle (not enforced).
// Reset (i_rst_n low, synchronous) sets smooth mode on and a knot count of
// one; the knot table is not cleared and must be loaded before queries.
module circular_keyframe_blend_selector
    import ckbs_pkg::*;
#(
    parameter int MAX_KNOTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_operation,
    input  logic [$clog2(MAX_KNOTS)-1:0]   i_knot_index,
    input  logic [TIME_W-1:0]              i_knot_time,
    input  logic [TIME_W-1:0]              i_query_time,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [$clog2(MAX_KNOTS+1)-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [$clog2(MAX_KNOTS)-1:0]   o_bottom_index,
    output logic [$clog2(MAX_KNOTS)-1:0]   o_top_index,
    output logic [FRAC_BITS:0]             o_blend
);

    t_cmd    w_cmd;
    t_status w_status;

    ckbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    ckbs_datapath #(
        .MAX_KNOTS(MAX_KNOTS),
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_knot_index   (i_knot_index),
        .i_knot_time    (i_knot_time),
        .i_query_time   (i_query_time),
        .o_valid        (o_valid),
        .o_bottom_index (o_bottom_index),
        .o_top_index    (o_top_index),
        .o_blend        (o_blend)
    );

endmodule

FILE: design/ckbs_checker.sv
// Port-level checks of the blend selector and their bind to the top level.
module ckbs_checker
    import ckbs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_operation,
    input logic               o_valid,
    input logic [FRAC_BITS:0] o_blend
);

    localparam logic [FRAC_BITS:0] BLEND_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // A query transfer makes the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_op'(i_operation) == OP_QUERY)) |=> busy)
        else $error("query transfer did not raise busy");

    // A load completes at its transfer
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_op'(i_operation) == OP_LOAD)) |=> !busy)
        else $error("load transfer raised busy");

    // A result ends a busy period
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of a query");

    // Blend never exceeds one
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_blend <= BLEND_ONE))
        else $error("blend above one");

endmodule

bind circular_keyframe_blend_selector ckbs_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_ckbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .o_blend     (o_blend)
);
